// File: rtl/core/vector3_arithmetic_unit_defines.svh
// ----------------------------------------------------------------------------
// Vector3 arithmetic unit assertion macros
// Shared assertion shorthands; the enclosing module provides clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef VECTOR3_ARITHMETIC_UNIT_DEFINES_SVH
`define VECTOR3_ARITHMETIC_UNIT_DEFINES_SVH

`define VAU_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("vector3 arithmetic unit assertion failed");

`define VAU_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("vector3 arithmetic unit assertion failed");

`endif

// File: rtl/core/vau_pkg.sv
// ----------------------------------------------------------------------------
// Vector3 arithmetic unit package
// Widths, command codes, shared types and helper functions.
// ----------------------------------------------------------------------------
package vau_pkg;

  localparam int Q_W        = 32;
  localparam int FRAC_BITS  = 16;
  localparam int LANES      = 3;
  localparam int LIN_W      = Q_W + 1;
  localparam int PW         = 2 * Q_W;
  localparam int DIFF_W     = PW + 1;
  localparam int SUM3_W     = PW + 2;
  localparam int WIDE_W     = PW + 4;
  localparam int SQ_W       = PW;
  localparam int ROOT_W     = Q_W;
  localparam int REM_W      = ROOT_W + 4;
  localparam int SQ_STAGES  = ROOT_W;
  localparam int DVD_W      = Q_W + FRAC_BITS;
  localparam int DVS_W      = Q_W;
  localparam int DIV_STAGES = DVD_W;
  localparam int SIDE_N     = 3 + SQ_STAGES + DIV_STAGES;
  localparam int SQ_IDX     = 2 + SQ_STAGES;

  localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  typedef enum logic [3:0] {
    CMD_ADD   = 4'd0,
    CMD_SUB   = 4'd1,
    CMD_MUL   = 4'd2,
    CMD_DIV   = 4'd3,
    CMD_DOT   = 4'd4,
    CMD_CROSS = 4'd5,
    CMD_MAG   = 4'd6,
    CMD_NORM  = 4'd7,
    CMD_EQ    = 4'd8,
    CMD_DIR   = 4'd9
  } cmd_t;

  typedef struct packed {
    logic [Q_W-1:0] val;
    logic           sat;
  } satq_t;

  typedef struct packed {
    logic [Q_W-1:0]       res;
    logic                 sat;
    logic signed [PW-1:0] p0;
  } lane_res_t;

  typedef struct packed {
    cmd_t                      cmd;
    logic [LANES-1:0][Q_W-1:0] a;
    logic [LANES-1:0][Q_W-1:0] b;
    logic                      eq;
    logic [LANES-1:0][Q_W-1:0] vec;
    logic                      vsat;
    logic [Q_W-1:0]            scal;
    logic                      ssat;
  } side_t;

  // Clamps a wide signed value to the fixed-point range.
  function automatic satq_t sat_q(input logic signed [WIDE_W-1:0] v);
    satq_t r;
    r.sat = !((&v[WIDE_W-1:Q_W-1]) || !(|v[WIDE_W-1:Q_W-1]));
    if (r.sat) begin
      r.val = v[WIDE_W-1] ? Q_MIN : Q_MAX;
    end else begin
      r.val = v[Q_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [Q_W-1:0] abs_u(input logic [Q_W-1:0] x);
    return x[Q_W-1] ? (~x + 1'b1) : x;
  endfunction

endpackage

// File: rtl/core/vau_lane.sv
// ----------------------------------------------------------------------------
// Vector3 arithmetic unit lane
// One component lane: operand selection, products, and per-component results.
// ----------------------------------------------------------------------------
module vau_lane (
  input  logic                          clk,
  input  logic                          adv,
  input  vau_pkg::cmd_t                 cmd,
  input  logic signed [vau_pkg::Q_W-1:0] a_i,
  input  logic signed [vau_pkg::Q_W-1:0] a_j,
  input  logic signed [vau_pkg::Q_W-1:0] a_k,
  input  logic signed [vau_pkg::Q_W-1:0] b_i,
  input  logic signed [vau_pkg::Q_W-1:0] b_j,
  input  logic signed [vau_pkg::Q_W-1:0] b_k,
  output vau_pkg::lane_res_t            lane_out
);

  logic signed [vau_pkg::Q_W-1:0]    x0, y0, x1, y1;
  logic signed [vau_pkg::PW-1:0]     p0_nxt, p1_nxt;
  logic signed [vau_pkg::LIN_W-1:0]  lin_nxt;
  logic signed [vau_pkg::PW-1:0]     p0_r, p1_r;
  logic signed [vau_pkg::LIN_W-1:0]  lin_r;
  vau_pkg::cmd_t                     cmd_r;
  logic signed [vau_pkg::DIFF_W-1:0] cdiff;
  vau_pkg::satq_t                    sq_nxt;
  vau_pkg::lane_res_t                out_r;

  always_comb begin
    x0 = a_i;
    y0 = b_i;
    x1 = a_k;
    y1 = b_j;
    unique case (cmd)
      vau_pkg::CMD_CROSS: begin
        x0 = a_j;
        y0 = b_k;
      end
      vau_pkg::CMD_MAG, vau_pkg::CMD_NORM: begin
        y0 = a_i;
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (cmd)
      vau_pkg::CMD_SUB: lin_nxt = vau_pkg::LIN_W'(a_i) - vau_pkg::LIN_W'(b_i);
      vau_pkg::CMD_DIR: lin_nxt = vau_pkg::LIN_W'(b_i) - vau_pkg::LIN_W'(a_i);
      default:          lin_nxt = vau_pkg::LIN_W'(a_i) + vau_pkg::LIN_W'(b_i);
    endcase
  end

  assign p0_nxt = x0 * y0;
  assign p1_nxt = x1 * y1;

  always_ff @(posedge clk) begin
    if (adv) begin
      p0_r  <= p0_nxt;
      p1_r  <= p1_nxt;
      lin_r <= lin_nxt;
      cmd_r <= cmd;
    end
  end

  assign cdiff = vau_pkg::DIFF_W'(p0_r) - vau_pkg::DIFF_W'(p1_r);

  always_comb begin
    unique case (cmd_r)
      vau_pkg::CMD_ADD, vau_pkg::CMD_SUB, vau_pkg::CMD_DIR:
        sq_nxt = vau_pkg::sat_q(vau_pkg::WIDE_W'(lin_r));
      vau_pkg::CMD_MUL:
        sq_nxt = vau_pkg::sat_q(vau_pkg::WIDE_W'(p0_r >>> vau_pkg::FRAC_BITS));
      vau_pkg::CMD_CROSS:
        sq_nxt = vau_pkg::sat_q(vau_pkg::WIDE_W'(cdiff >>> vau_pkg::FRAC_BITS));
      default:
        sq_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.res <= sq_nxt.val;
      out_r.sat <= sq_nxt.sat;
      out_r.p0  <= p0_r;
    end
  end

  assign lane_out = out_r;

endmodule

// File: rtl/core/vau_sqrt.sv
// ----------------------------------------------------------------------------
// Vector3 arithmetic unit square root
// Pipelined restoring integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module vau_sqrt (
  input  logic                        clk,
  input  logic                        adv,
  input  logic [vau_pkg::SQ_W-1:0]    radicand,
  output logic [vau_pkg::ROOT_W-1:0]  root
);

  logic [vau_pkg::SQ_W-1:0]   x_r   [vau_pkg::SQ_STAGES];
  logic [vau_pkg::REM_W-1:0]  rem_r [vau_pkg::SQ_STAGES];
  logic [vau_pkg::ROOT_W-1:0] q_r   [vau_pkg::SQ_STAGES];

  for (genvar s = 0; s < vau_pkg::SQ_STAGES; s++) begin : g_stage
    logic [vau_pkg::SQ_W-1:0]   x_in;
    logic [vau_pkg::REM_W-1:0]  rem_in, sh, trial;
    logic [vau_pkg::ROOT_W-1:0] q_in;
    logic                       ge;

    if (s == 0) begin : g_first
      assign x_in   = radicand;
      assign rem_in = '0;
      assign q_in   = '0;
    end else begin : g_next
      assign x_in   = x_r[s-1];
      assign rem_in = rem_r[s-1];
      assign q_in   = q_r[s-1];
    end

    assign sh    = {rem_in[vau_pkg::REM_W-3:0], x_in[vau_pkg::SQ_W-1 -: 2]};
    assign trial = vau_pkg::REM_W'({q_in, 2'b01});
    assign ge    = (sh >= trial);

    always_ff @(posedge clk) begin
      if (adv) begin
        x_r[s]   <= x_in << 2;
        rem_r[s] <= ge ? (sh - trial) : sh;
        q_r[s]   <= {q_in[vau_pkg::ROOT_W-2:0], ge};
      end
    end
  end

  assign root = q_r[vau_pkg::SQ_STAGES-1];

endmodule

// File: rtl/core/vau_div.sv
// ----------------------------------------------------------------------------
// Vector3 arithmetic unit divider
// Pipelined restoring unsigned divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module vau_div (
  input  logic                       clk,
  input  logic                       adv,
  input  logic [vau_pkg::DVD_W-1:0]  dividend,
  input  logic [vau_pkg::DVS_W-1:0]  divisor,
  output logic [vau_pkg::DVD_W-1:0]  quotient
);

  logic [vau_pkg::DVD_W-1:0] n_r [vau_pkg::DIV_STAGES];
  logic [vau_pkg::DVS_W-1:0] d_r [vau_pkg::DIV_STAGES];
  logic [vau_pkg::DVS_W-1:0] r_r [vau_pkg::DIV_STAGES];
  logic [vau_pkg::DVD_W-1:0] q_r [vau_pkg::DIV_STAGES];

  for (genvar s = 0; s < vau_pkg::DIV_STAGES; s++) begin : g_stage
    logic [vau_pkg::DVD_W-1:0] n_in, q_in;
    logic [vau_pkg::DVS_W-1:0] d_in, r_in;
    logic [vau_pkg::DVS_W:0]   r_sh, r_sub;
    logic                      ge;

    if (s == 0) begin : g_first
      assign n_in = dividend;
      assign d_in = divisor;
      assign r_in = '0;
      assign q_in = '0;
    end else begin : g_next
      assign n_in = n_r[s-1];
      assign d_in = d_r[s-1];
      assign r_in = r_r[s-1];
      assign q_in = q_r[s-1];
    end

    assign r_sh  = {r_in, n_in[vau_pkg::DVD_W-1]};
    assign r_sub = r_sh - {1'b0, d_in};
    assign ge    = (r_sh >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      if (adv) begin
        n_r[s] <= n_in << 1;
        d_r[s] <= d_in;
        r_r[s] <= ge ? r_sub[vau_pkg::DVS_W-1:0] : r_sh[vau_pkg::DVS_W-1:0];
        q_r[s] <= {q_in[vau_pkg::DVD_W-2:0], ge};
      end
    end
  end

  assign quotient = q_r[vau_pkg::DIV_STAGES-1];

endmodule

// File: rtl/core/vector3_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// Vector3 arithmetic unit: pipelined, one transaction per cycle unless the
// output stalls. Every transaction passes in order through the 32-stage
// square root and the 48-stage dividers. Synchronous active-low reset
// empties the pipeline; no other state is kept.
// ----------------------------------------------------------------------------
`include "vector3_arithmetic_unit_defines.svh"

module vector3_arithmetic_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [3:0]        in_cmd,
  input  logic signed [31:0] in_a_x,
  input  logic signed [31:0] in_a_y,
  input  logic signed [31:0] in_a_z,
  input  logic signed [31:0] in_b_x,
  input  logic signed [31:0] in_b_y,
  input  logic signed [31:0] in_b_z,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [31:0] out_res_x,
  output logic signed [31:0] out_res_y,
  output logic signed [31:0] out_res_z,
  output logic signed [31:0] out_scalar,
  output logic              out_is_equal,
  output logic              out_div_zero,
  output logic              out_saturated
);

  localparam int L = vau_pkg::LANES;
  localparam int QW = vau_pkg::Q_W;

  logic                         adv;
  logic signed [QW-1:0]         in_a [L];
  logic signed [QW-1:0]         in_b [L];
  vau_pkg::cmd_t                in_cmd_e;
  vau_pkg::lane_res_t           lr [L];
  logic [vau_pkg::SIDE_N-1:0]   vld_r;
  vau_pkg::side_t               side_r [vau_pkg::SIDE_N];
  vau_pkg::side_t               side_in, side_m, side_s, sl;
  logic signed [vau_pkg::SUM3_W-1:0] sum3;
  vau_pkg::satq_t               dotq;
  logic [vau_pkg::SQ_W-1:0]     sq_r;
  logic [vau_pkg::ROOT_W-1:0]   root;
  logic [vau_pkg::DVD_W-1:0]    dvd [L];
  logic [vau_pkg::DVS_W-1:0]    dvs [L];
  logic [vau_pkg::DVD_W-1:0]    quo [L];
  logic                         neg_q [L];
  logic                         ovf [L];
  logic                         fsat [L];
  logic [QW-1:0]                fval [L];
  logic                         zero_a;
  logic [L-1:0][QW-1:0]         o_vec;
  logic [QW-1:0]                o_scal;
  logic                         o_dz, o_sat;
  logic                         out_valid_r;
  logic [QW-1:0]                res_x_r, res_y_r, res_z_r, scalar_r;
  logic                         eq_r, dz_r, sat_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;
  assign in_cmd_e = vau_pkg::cmd_t'(in_cmd);

  assign in_a[0] = in_a_x;
  assign in_a[1] = in_a_y;
  assign in_a[2] = in_a_z;
  assign in_b[0] = in_b_x;
  assign in_b[1] = in_b_y;
  assign in_b[2] = in_b_z;

  for (genvar i = 0; i < L; i++) begin : g_lane
    vau_lane u_lane (
      .clk      (clk),
      .adv      (adv),
      .cmd      (in_cmd_e),
      .a_i      (in_a[i]),
      .a_j      (in_a[(i+1)%L]),
      .a_k      (in_a[(i+2)%L]),
      .b_i      (in_b[i]),
      .b_j      (in_b[(i+1)%L]),
      .b_k      (in_b[(i+2)%L]),
      .lane_out (lr[i])
    );
  end

  always_comb begin
    side_in = '0;
    side_in.cmd = in_cmd_e;
    for (int i = 0; i < L; i++) begin
      side_in.a[i] = in_a[i];
      side_in.b[i] = in_b[i];
    end
    side_in.eq = (in_a_x == in_b_x) && (in_a_y == in_b_y) && (in_a_z == in_b_z);
  end

  // The merging stage sums the lane products for the dot product and the
  // squared magnitude.
  assign sum3 = vau_pkg::SUM3_W'($signed(lr[0].p0)) + vau_pkg::SUM3_W'($signed(lr[1].p0))
              + vau_pkg::SUM3_W'($signed(lr[2].p0));
  assign dotq = vau_pkg::sat_q(vau_pkg::WIDE_W'(sum3 >>> vau_pkg::FRAC_BITS));

  always_comb begin
    side_m = side_r[1];
    for (int i = 0; i < L; i++) begin
      side_m.vec[i] = lr[i].res;
    end
    side_m.vsat = lr[0].sat || lr[1].sat || lr[2].sat;
    side_m.scal = '0;
    side_m.ssat = 1'b0;
    if (side_r[1].cmd == vau_pkg::CMD_DOT) begin
      side_m.scal = dotq.val;
      side_m.ssat = dotq.sat;
    end
  end

  always_comb begin
    side_s = side_r[vau_pkg::SQ_IDX];
    if (side_r[vau_pkg::SQ_IDX].cmd == vau_pkg::CMD_MAG) begin
      side_s.ssat = root[QW-1];
      side_s.scal = root[QW-1] ? vau_pkg::Q_MAX : root;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side_in;
      side_r[1] <= side_r[0];
      side_r[2] <= side_m;
      sq_r      <= sum3[vau_pkg::SQ_W-1:0];
      for (int k = 3; k < vau_pkg::SIDE_N; k++) begin
        side_r[k] <= (k == vau_pkg::SQ_IDX + 1) ? side_s : side_r[k-1];
      end
    end
  end

  vau_sqrt u_sqrt (
    .clk      (clk),
    .adv      (adv),
    .radicand (sq_r),
    .root     (root)
  );

  for (genvar i = 0; i < L; i++) begin : g_div
    assign dvd[i] = {vau_pkg::abs_u(side_r[vau_pkg::SQ_IDX].a[i]),
                     {vau_pkg::FRAC_BITS{1'b0}}};
    assign dvs[i] = (side_r[vau_pkg::SQ_IDX].cmd == vau_pkg::CMD_DIV) ?
                    vau_pkg::abs_u(side_r[vau_pkg::SQ_IDX].b[i]) : root;

    vau_div u_div (
      .clk      (clk),
      .adv      (adv),
      .dividend (dvd[i]),
      .divisor  (dvs[i]),
      .quotient (quo[i])
    );
  end

  assign sl     = side_r[vau_pkg::SIDE_N-1];
  assign zero_a = (sl.a == '0);

  always_comb begin
    for (int i = 0; i < L; i++) begin
      neg_q[i] = (sl.cmd == vau_pkg::CMD_DIV) ? (sl.a[i][QW-1] ^ sl.b[i][QW-1])
                                              : sl.a[i][QW-1];
      ovf[i] = |quo[i][vau_pkg::DVD_W-1:QW];
      if (neg_q[i]) begin
        fsat[i] = ovf[i] || (quo[i][QW-1] && (|quo[i][QW-2:0]));
        fval[i] = fsat[i] ? vau_pkg::Q_MIN : (~quo[i][QW-1:0] + 1'b1);
      end else begin
        fsat[i] = ovf[i] || quo[i][QW-1];
        fval[i] = fsat[i] ? vau_pkg::Q_MAX : quo[i][QW-1:0];
      end
    end
  end

  always_comb begin
    o_vec  = '0;
    o_scal = '0;
    o_dz   = 1'b0;
    o_sat  = 1'b0;
    unique case (sl.cmd)
      vau_pkg::CMD_ADD, vau_pkg::CMD_SUB, vau_pkg::CMD_MUL,
      vau_pkg::CMD_CROSS, vau_pkg::CMD_DIR: begin
        o_vec = sl.vec;
        o_sat = sl.vsat;
      end
      vau_pkg::CMD_DIV: begin
        for (int i = 0; i < L; i++) begin
          if (sl.b[i] == '0) begin
            o_dz = 1'b1;
            if (sl.a[i] == '0) begin
              o_vec[i] = '0;
            end else begin
              o_vec[i] = sl.a[i][QW-1] ? vau_pkg::Q_MIN : vau_pkg::Q_MAX;
            end
          end else begin
            o_vec[i] = fval[i];
            o_sat = o_sat || fsat[i];
          end
        end
      end
      vau_pkg::CMD_NORM: begin
        if (zero_a) begin
          o_dz = 1'b1;
        end else begin
          for (int i = 0; i < L; i++) begin
            o_vec[i] = fval[i];
            o_sat = o_sat || fsat[i];
          end
        end
      end
      vau_pkg::CMD_DOT, vau_pkg::CMD_MAG: begin
        o_scal = sl.scal;
        o_sat  = sl.ssat;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[vau_pkg::SIDE_N-2:0], in_valid};
      out_valid_r <= vld_r[vau_pkg::SIDE_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_x_r  <= o_vec[0];
      res_y_r  <= o_vec[1];
      res_z_r  <= o_vec[2];
      scalar_r <= o_scal;
      eq_r     <= sl.eq;
      dz_r     <= o_dz;
      sat_r    <= o_sat;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_res_x     = res_x_r;
  assign out_res_y     = res_y_r;
  assign out_res_z     = res_z_r;
  assign out_scalar    = scalar_r;
  assign out_is_equal  = eq_r;
  assign out_div_zero  = dz_r;
  assign out_saturated = sat_r;

  `VAU_ASSERT_NEXT(a_pipe_frozen, in_stall, $stable(vld_r))
  `VAU_ASSERT_NEXT(a_last_to_out, vld_r[vau_pkg::SIDE_N-1] && !in_stall, out_valid)
  `VAU_ASSERT_IMPL(a_scalar_no_vec, out_valid && (out_scalar != '0),
                   (out_res_x == '0) && (out_res_y == '0) && (out_res_z == '0))
  `VAU_ASSERT_IMPL(a_dz_no_scalar, out_valid && out_div_zero, out_scalar == '0)

endmodule

// File: dv/vector3_arithmetic_unit_checker.sv
// ----------------------------------------------------------------------------
// Vector3 arithmetic unit result checker
// Watches both channels, computes the expected result of every accepted input
// transaction and compares each output transaction against the oldest one.
// ----------------------------------------------------------------------------
module vector3_arithmetic_unit_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [3:0]         in_cmd,
  input  logic signed [31:0] in_a_x,
  input  logic signed [31:0] in_a_y,
  input  logic signed [31:0] in_a_z,
  input  logic signed [31:0] in_b_x,
  input  logic signed [31:0] in_b_y,
  input  logic signed [31:0] in_b_z,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_res_x,
  input  logic signed [31:0] out_res_y,
  input  logic signed [31:0] out_res_z,
  input  logic signed [31:0] out_scalar,
  input  logic               out_is_equal,
  input  logic               out_div_zero,
  input  logic               out_saturated,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] s;
    logic               eq;
    logic               dz;
    logic               sat;
  } vec_result_t;

  vec_result_t expected_q[$];

  assign pending = expected_q.size();

  function automatic logic signed [31:0] clamp(input logic signed [127:0] v,
                                               inout logic sat);
    if (v > 128'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -128'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] fx_quot(input logic signed [127:0] n,
                                                 input logic signed [127:0] d,
                                                 inout logic dz, inout logic sat);
    logic signed [127:0] q;
    if (d == 0) begin
      dz = 1'b1;
      return n > 0 ? 32'sh7fffffff : (n < 0 ? 32'sh80000000 : 32'sd0);
    end
    q = (n <<< vau_pkg::FRAC_BITS) / d;
    return clamp(q, sat);
  endfunction

  function automatic logic [127:0] root_floor(input logic [127:0] v);
    logic [127:0] r;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      if ((r | (128'd1 << b)) * (r | (128'd1 << b)) <= v) r = r | (128'd1 << b);
    end
    return r;
  endfunction

  function automatic vec_result_t predict(input logic [3:0] cmd,
                                          input logic signed [31:0] a [3],
                                          input logic signed [31:0] b [3]);
    vec_result_t e;
    logic signed [127:0] r [3];
    logic signed [127:0] acc, m;
    logic dz, sat;
    dz = 1'b0;
    sat = 1'b0;
    e = '0;
    e.eq = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);
    for (int i = 0; i < 3; i++) r[i] = 0;
    case (cmd)
      vau_pkg::CMD_ADD:
        for (int i = 0; i < 3; i++) r[i] = clamp(128'(a[i]) + b[i], sat);
      vau_pkg::CMD_SUB:
        for (int i = 0; i < 3; i++) r[i] = clamp(128'(a[i]) - b[i], sat);
      vau_pkg::CMD_DIR:
        for (int i = 0; i < 3; i++) r[i] = clamp(128'(b[i]) - a[i], sat);
      vau_pkg::CMD_MUL:
        for (int i = 0; i < 3; i++)
          r[i] = clamp((128'(a[i]) * b[i]) >>> vau_pkg::FRAC_BITS, sat);
      vau_pkg::CMD_DIV:
        for (int i = 0; i < 3; i++) r[i] = fx_quot(a[i], b[i], dz, sat);
      vau_pkg::CMD_DOT: begin
        acc = 128'(a[0]) * b[0] + 128'(a[1]) * b[1] + 128'(a[2]) * b[2];
        e.s = clamp(acc >>> vau_pkg::FRAC_BITS, sat);
      end
      vau_pkg::CMD_CROSS:
        for (int i = 0; i < 3; i++) begin
          acc = 128'(a[(i+1)%3]) * b[(i+2)%3] - 128'(a[(i+2)%3]) * b[(i+1)%3];
          r[i] = clamp(acc >>> vau_pkg::FRAC_BITS, sat);
        end
      vau_pkg::CMD_MAG, vau_pkg::CMD_NORM: begin
        m = root_floor(128'(a[0]) * a[0] + 128'(a[1]) * a[1] + 128'(a[2]) * a[2]);
        if (cmd == vau_pkg::CMD_MAG) begin
          e.s = clamp(m, sat);
        end else if (m == 0) begin
          dz = 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) r[i] = fx_quot(a[i], m, dz, sat);
        end
      end
      default: ;
    endcase
    e.x = r[0][31:0];
    e.y = r[1][31:0];
    e.z = r[2][31:0];
    e.dz = dz;
    e.sat = sat;
    return e;
  endfunction

  always @(posedge clk) begin
    logic signed [31:0] a [3];
    logic signed [31:0] b [3];
    vec_result_t e;
    if (rst_n && in_valid && !in_stall) begin
      a[0] = in_a_x; a[1] = in_a_y; a[2] = in_a_z;
      b[0] = in_b_x; b[1] = in_b_y; b[2] = in_b_z;
      expected_q.push_back(predict(in_cmd, a, b));
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected output transaction");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_res_x !== e.x) begin
          $error("res_x expected %h actual %h", e.x, out_res_x); errors++;
        end
        if (out_res_y !== e.y) begin
          $error("res_y expected %h actual %h", e.y, out_res_y); errors++;
        end
        if (out_res_z !== e.z) begin
          $error("res_z expected %h actual %h", e.z, out_res_z); errors++;
        end
        if (out_scalar !== e.s) begin
          $error("scalar expected %h actual %h", e.s, out_scalar); errors++;
        end
        if (out_is_equal !== e.eq) begin
          $error("is_equal expected %b actual %b", e.eq, out_is_equal); errors++;
        end
        if (out_div_zero !== e.dz) begin
          $error("div_zero expected %b actual %b", e.dz, out_div_zero); errors++;
        end
        if (out_saturated !== e.sat) begin
          $error("saturated expected %b actual %b", e.sat, out_saturated); errors++;
        end
      end
    end
  end

endmodule

// File: dv/vector3_arithmetic_unit_tb.sv
// ----------------------------------------------------------------------------
// Vector3 arithmetic unit testbench
// Drives directed corner cases and random vector pairs with random gaps and
// output stalls, including a long stall, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module vector3_arithmetic_unit_tb;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [3:0]         in_cmd;
  logic signed [31:0] in_a_x, in_a_y, in_a_z, in_b_x, in_b_y, in_b_z;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_res_x, out_res_y, out_res_z, out_scalar;
  logic               out_is_equal, out_div_zero, out_saturated;
  int                 errors;
  int                 pending;
  bit                 hold_output;

  vector3_arithmetic_unit dut (.*);

  vector3_arithmetic_unit_checker checker_i (.*);

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [31:0] rand_comp();
    case ($urandom_range(0, 6))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 0;
      3: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      4: return $signed($urandom_range(0, 32'h3ffffff)) - 32'sh2000000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send(input logic [3:0] cmd, input logic signed [31:0] ax,
                      input logic signed [31:0] ay, input logic signed [31:0] az,
                      input logic signed [31:0] bx, input logic signed [31:0] by,
                      input logic signed [31:0] bz);
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_a_x <= ax; in_a_y <= ay; in_a_z <= az;
    in_b_x <= bx; in_b_y <= by; in_b_z <= bz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (hold_output) out_stall <= 1'b1;
    else out_stall <= (gap_len() != 0);
  end

  initial begin
    hold_output = 1'b1;
    @(posedge clk);
    repeat (150) @(posedge clk);
    hold_output = 1'b0;
    repeat (400) @(posedge clk);
    hold_output = 1'b1;
    repeat (300) @(posedge clk);
    hold_output = 1'b0;
  end

  initial begin
    #(12 * 400000);
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic signed [31:0] ax, ay, az;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = '0;
    {in_a_x, in_a_y, in_a_z, in_b_x, in_b_y, in_b_z} = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    for (int c = 0; c < 16; c++)
      send(c[3:0], 32'sh7fffffff, 32'sh80000000, 32'sh10000,
           32'sh80000000, 32'sh7fffffff, -32'sh18000);
    send(vau_pkg::CMD_DIV, 32'sh10000, -32'sh10000, 0, 0, 0, 0);
    send(vau_pkg::CMD_NORM, 0, 0, 0, 1, 2, 3);
    send(vau_pkg::CMD_EQ, 32'sh12345, -5, 7, 32'sh12345, -5, 7);
    send(vau_pkg::CMD_MUL, -1, 32'sh7fffffff, 32'sh80000000, 1, 32'sh7fffffff,
         32'sh80000000);
    send(vau_pkg::CMD_MAG, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 0);
    send(vau_pkg::CMD_NORM, 1, 0, -1, 0, 0, 0);
    send(vau_pkg::CMD_DIV, 32'sh7fffffff, 32'sh80000000, 1, 1, 1, 32'sh80000000);
    idle(1);
    while (pending != 0) @(posedge clk);
    for (int n = 0; n < 700; n++) begin
      ax = rand_comp(); ay = rand_comp(); az = rand_comp();
      if ($urandom_range(0, 9) == 0)
        send(4'($urandom_range(0, 9)), ax, ay, az, ax, ay, az);
      else
        send(4'($urandom_range(0, 15)), ax, ay, az, rand_comp(), rand_comp(),
             rand_comp());
      idle(gap_len());
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && pending == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
